[rtl/hds_pkg.sv]
// ============================================================================
// hds_pkg: shared constants and types for the heat diffusion stencil step
// Register map, request codes, field widths and the control group that
// travels with each value through the arithmetic pipeline.
// ============================================================================
package hds_pkg;

    // Default sizing of the block
    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int VALUE_BITS_DEFAULT = 24;

    // Configuration port and register fields
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 16;
    localparam int GRID_WIDTH_BITS = 11;
    localparam int ALPHA_BITS      = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA      = 1'b1;

    localparam int                    GRID_WIDTH_MIN   = 3;
    localparam int                    GRID_WIDTH_RESET = 64;
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET      = 16'd6554;

    // Request codes on req_type
    localparam logic REQ_CELL  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Arithmetic pipeline depth and the result queue behind it
    localparam int ARITH_STAGES     = 3;
    localparam int STAGE_COUNT_BITS = $clog2(ARITH_STAGES + 1);
    localparam int OUT_FIFO_DEPTH   = 8;

    typedef struct packed {
        logic valid;
        logic sten;
        logic last;
    } arith_ctl_t;

endpackage

[rtl/heat_diffusion_stencil_step.sv]
// ============================================================================
// heat_diffusion_stencil_step: one explicit step of 2D heat diffusion
// Line-buffered five-point stencil over a raster stream of grid cells.
// ============================================================================
// Grid cells enter in raster order, one item per clock, and results leave in
// raster order one row plus one cell behind. Interior cells become
// centre + alpha * (left + right + up + down - 4 * centre), rounded half up
// and saturated; border cells pass through. After the cell flagged last_cell,
// send grid_width + 1 drain items to flush the last row; the final result
// carries last_out. Cells sent while a drain is pending are dropped. Two row
// RAMs (read when the item is taken, written back in the cycle after that)
// hold the two rows above; a column is read again no sooner than three items
// after the item that writes it, so no forwarding is needed. Throughput is one
// item per clock while not stalled; results pass the arithmetic pipeline into
// the output queue. The input stalls only while eight results are queued or
// in flight. Neither row RAM is cleared after reset: the first rows written
// fill them. Writing grid_width restarts the grid; alpha takes effect at once.
// ============================================================================
module heat_diffusion_stencil_step #(
    parameter int MAX_WIDTH  = hds_pkg::MAX_WIDTH_DEFAULT,
    parameter int VALUE_BITS = hds_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic signed [VALUE_BITS-1:0]         cell_value,
    input  logic                                 last_cell,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [VALUE_BITS-1:0]         new_value,
    output logic                                 last_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [hds_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int PW  = $clog2(MAX_WIDTH + 2);
    localparam int RESET_WIDTH = (hds_pkg::GRID_WIDTH_RESET > MAX_WIDTH)
                               ? MAX_WIDTH : hds_pkg::GRID_WIDTH_RESET;
    localparam int FIFO_DEPTH = hds_pkg::OUT_FIFO_DEPTH;
    localparam int FAW = $clog2(FIFO_DEPTH);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {ROW_FIRST, ROW_SECOND, ROW_LATER} row_pos_t;

    // Configuration and grid position
    logic [CW-1:0]                  width_reg, width_next, width_clamped;
    logic [hds_pkg::ALPHA_BITS-1:0] alpha_reg, alpha_next;
    logic [AW-1:0]                  col_reg, col_next;
    row_pos_t                       row_reg, row_next;
    logic [PW-1:0]                  pending_reg, pending_next;

    // Item held for the cycle in which the row RAMs answer
    logic                           op_valid_reg;
    logic                           op_grid_reg;
    logic                           op_emit_reg;
    logic                           op_sten_reg;
    logic                           op_last_reg;
    logic                           op_zero_reg;
    logic [AW-1:0]                  op_col_reg;
    logic signed [VALUE_BITS-1:0]   op_x_reg;

    // Column window: up, centre and down of the previous column, and the
    // centre of the column before that (the left neighbour)
    logic signed [VALUE_BITS-1:0]   up_reg;
    logic signed [VALUE_BITS-1:0]   mid_reg;
    logic signed [VALUE_BITS-1:0]   down_reg;
    logic signed [VALUE_BITS-1:0]   left_reg;

    // Result queue
    logic signed [VALUE_BITS-1:0]   fifo_value_reg [FIFO_DEPTH];
    logic                           fifo_last_reg  [FIFO_DEPTH];
    logic [FAW-1:0]                 wr_ptr_reg;
    logic [FAW-1:0]                 rd_ptr_reg;
    logic [FCW-1:0]                 fifo_count_reg;

    logic                           in_accept;
    logic                           out_accept;
    logic                           cfg_write;
    logic                           restart_cfg;
    logic                           have_pending;
    logic                           cell_op;
    logic                           drain_op;
    logic                           drain_final;
    logic                           emits;
    logic [CW-1:0]                  col_inc;
    logic                           col_wrap;
    logic [FCW:0]                   outstanding;

    logic [VALUE_BITS-1:0]          rd_up_raw;
    logic [VALUE_BITS-1:0]          rd_mid_raw;
    logic signed [VALUE_BITS-1:0]   rd_up;
    logic signed [VALUE_BITS-1:0]   rd_mid;
    logic                           ram_we;

    hds_pkg::arith_ctl_t                    arith_in_ctl;
    hds_pkg::arith_ctl_t                    arith_out_ctl;
    logic signed [VALUE_BITS-1:0]           arith_center;
    logic signed [VALUE_BITS-1:0]           arith_value;
    logic [hds_pkg::STAGE_COUNT_BITS-1:0]   arith_in_flight;

    // ------------------------------------------------------------------------
    // Handshakes. Hold the input while every queue slot is spoken for.
    // ------------------------------------------------------------------------
    assign outstanding = (FCW+1)'(fifo_count_reg)
                       + (FCW+1)'(op_valid_reg && op_emit_reg)
                       + (FCW+1)'(arith_in_flight);
    assign in_stall   = (outstanding >= (FCW+1)'(FIFO_DEPTH));
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (fifo_count_reg != '0);
    assign out_accept = out_valid && !out_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign restart_cfg = cfg_write && (cfg_index == hds_pkg::REG_GRID_WIDTH);

    // ------------------------------------------------------------------------
    // Item decode against the current grid position
    // ------------------------------------------------------------------------
    assign have_pending = (pending_reg != '0);
    assign cell_op      = in_accept && (req_type == hds_pkg::REQ_CELL) && !have_pending;
    assign drain_op     = in_accept && (req_type == hds_pkg::REQ_DRAIN) && have_pending;
    assign drain_final  = drain_op && (pending_reg == PW'(1));

    // Nothing leaves until the item is one row plus one cell into the grid
    assign emits    = (row_reg == ROW_LATER) || ((row_reg == ROW_SECOND) && (col_reg != '0));
    assign col_inc  = CW'(col_reg) + CW'(1);
    assign col_wrap = (col_inc >= width_reg);

    // Saturate a written grid width into the supported range
    always_comb
    begin
        if (32'(cfg_data[hds_pkg::GRID_WIDTH_BITS-1:0]) < hds_pkg::GRID_WIDTH_MIN)
        begin
            width_clamped = CW'(hds_pkg::GRID_WIDTH_MIN);
        end
        else if (32'(cfg_data[hds_pkg::GRID_WIDTH_BITS-1:0]) > MAX_WIDTH)
        begin
            width_clamped = CW'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = CW'(cfg_data[hds_pkg::GRID_WIDTH_BITS-1:0]);
        end
    end

    always_comb
    begin
        width_next   = width_reg;
        alpha_next   = alpha_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pending_next = pending_reg;

        // Advance the raster position; the row count stops at "two or more"
        if (cell_op || drain_op)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                if (row_reg == ROW_FIRST)
                begin
                    row_next = ROW_SECOND;
                end
                else
                begin
                    row_next = ROW_LATER;
                end
            end
            else
            begin
                col_next = col_inc[AW-1:0];
            end
        end

        if (cell_op && last_cell)
        begin
            pending_next = PW'(width_reg) + PW'(1);
        end

        if (drain_op)
        begin
            pending_next = pending_reg - PW'(1);
        end

        // Final drain item: start the next grid from the top
        if (drain_final)
        begin
            col_next = '0;
            row_next = ROW_FIRST;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                hds_pkg::REG_GRID_WIDTH:
                begin
                    width_next   = width_clamped;
                    col_next     = '0;
                    row_next     = ROW_FIRST;
                    pending_next = '0;
                end
                hds_pkg::REG_ALPHA:
                begin
                    alpha_next = cfg_data[hds_pkg::ALPHA_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CW'(RESET_WIDTH);
            alpha_reg    <= hds_pkg::ALPHA_RESET;
            col_reg      <= '0;
            row_reg      <= ROW_FIRST;
            pending_reg  <= '0;
            op_valid_reg <= 1'b0;
            op_grid_reg  <= 1'b0;
            op_emit_reg  <= 1'b0;
            op_sten_reg  <= 1'b0;
            op_last_reg  <= 1'b0;
            op_zero_reg  <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            alpha_reg    <= alpha_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pending_reg  <= pending_next;
            op_valid_reg <= cell_op || drain_op;
            op_grid_reg  <= cell_op;
            op_emit_reg  <= (cell_op && emits) || (drain_op && (emits || drain_final));
            op_sten_reg  <= cell_op && emits && (row_reg == ROW_LATER) && (col_reg >= AW'(2));
            op_last_reg  <= drain_final;
            op_zero_reg  <= drain_final && !emits;
        end
    end

    always_ff @(posedge clk)
    begin
        op_col_reg <= col_reg;
        op_x_reg   <= cell_value;
    end

    // ------------------------------------------------------------------------
    // Row RAMs: read at the item's column when it is taken; the next cycle
    // the row above moves up and the new cell goes into the middle row.
    // ------------------------------------------------------------------------
    assign ram_we = op_valid_reg && op_grid_reg;

    hds_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_col_reg),
        .wdata (rd_mid_raw),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (rd_up_raw)
    );

    hds_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_col_reg),
        .wdata (op_x_reg),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (rd_mid_raw)
    );

    assign rd_up  = rd_up_raw;
    assign rd_mid = rd_mid_raw;

    // ------------------------------------------------------------------------
    // Column window: shift in the column that the RAMs just returned
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= '0;
            mid_reg  <= '0;
            down_reg <= '0;
            left_reg <= '0;
        end
        else if (restart_cfg || (op_valid_reg && op_last_reg))
        begin
            up_reg   <= '0;
            mid_reg  <= '0;
            down_reg <= '0;
            left_reg <= '0;
        end
        else if (op_valid_reg)
        begin
            up_reg   <= rd_up;
            mid_reg  <= rd_mid;
            down_reg <= op_grid_reg ? op_x_reg : '0;
            left_reg <= mid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stencil arithmetic. Pass the centre through for border cells; a final
    // drain that has no cell of its own to show emits zero.
    // ------------------------------------------------------------------------
    assign arith_in_ctl.valid = op_valid_reg && op_emit_reg;
    assign arith_in_ctl.sten  = op_sten_reg;
    assign arith_in_ctl.last  = op_last_reg;
    assign arith_center       = op_zero_reg ? '0 : mid_reg;

    hds_arith #(
        .VALUE_BITS (VALUE_BITS)
    ) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .alpha     (alpha_reg),
        .in_ctl    (arith_in_ctl),
        .center    (arith_center),
        .left      (left_reg),
        .right     (rd_mid),
        .up        (up_reg),
        .down      (down_reg),
        .out_ctl   (arith_out_ctl),
        .out_value (arith_value),
        .in_flight (arith_in_flight)
    );

    // ------------------------------------------------------------------------
    // Result queue: parts the pipeline from a stalling consumer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (arith_out_ctl.valid)
        begin
            fifo_value_reg[wr_ptr_reg] <= arith_value;
            fifo_last_reg[wr_ptr_reg]  <= arith_out_ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (arith_out_ctl.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FAW'(1);
            end
            if (out_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + FAW'(1);
            end
            fifo_count_reg <= fifo_count_reg + FCW'(arith_out_ctl.valid) - FCW'(out_accept);
        end
    end

    assign new_value = fifo_value_reg[rd_ptr_reg];
    assign last_out  = fifo_last_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    // The credit count keeps a slot free for every result in flight
    a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        arith_out_ctl.valid |-> (fifo_count_reg != FCW'(FIFO_DEPTH)))
        else $error("result queue written while full");

    // A cell that arrives during a drain is dropped without effect
    a_cell_dropped_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (req_type == hds_pkg::REQ_CELL) && have_pending) |=> !op_valid_reg)
        else $error("cell taken while a drain was pending");

    // The final drain restarts the grid and carries the last flag
    a_final_drain_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        drain_final |=> ((col_reg == '0) && (row_reg == ROW_FIRST) && (pending_reg == '0)
                         && op_last_reg && op_emit_reg))
        else $error("final drain did not restart the grid");

    // Only an emitting grid cell goes through the stencil
    a_sten_only_grid: assert property (@(posedge clk) disable iff (!rst_n)
        op_sten_reg |-> (op_valid_reg && op_grid_reg && op_emit_reg))
        else $error("stencil flagged on an item that is not an emitting cell");
`endif

endmodule

[rtl/hds_ram.sv]
// ============================================================================
// hds_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module hds_ram #(
    parameter int WIDTH = hds_pkg::VALUE_BITS_DEFAULT,
    parameter int DEPTH = hds_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hds_arith.sv]
// ============================================================================
// hds_arith: five-point stencil arithmetic pipeline
// Sum of neighbours less four times the centre, scaled by alpha with
// round-half-up, added to the centre and saturated. Three register stages.
// ============================================================================
module hds_arith #(
    parameter int VALUE_BITS = hds_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [hds_pkg::ALPHA_BITS-1:0]           alpha,
    input  hds_pkg::arith_ctl_t                      in_ctl,
    input  logic signed [VALUE_BITS-1:0]             center,
    input  logic signed [VALUE_BITS-1:0]             left,
    input  logic signed [VALUE_BITS-1:0]             right,
    input  logic signed [VALUE_BITS-1:0]             up,
    input  logic signed [VALUE_BITS-1:0]             down,
    output hds_pkg::arith_ctl_t                      out_ctl,
    output logic signed [VALUE_BITS-1:0]             out_value,
    output logic [hds_pkg::STAGE_COUNT_BITS-1:0]     in_flight
);

    localparam int SUM_W  = VALUE_BITS + 3;
    localparam int PROD_W = SUM_W + hds_pkg::ALPHA_BITS + 1;
    localparam int Q_W    = PROD_W - hds_pkg::ALPHA_BITS;
    localparam int V_W    = Q_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        {{(PROD_W - hds_pkg::ALPHA_BITS){1'b0}}, 1'b1, {(hds_pkg::ALPHA_BITS - 1){1'b0}}};
    localparam logic signed [V_W-1:0] SAT_HI =
        {{(V_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [V_W-1:0] SAT_LO = ~SAT_HI;

    hds_pkg::arith_ctl_t         s1_ctl_reg;
    logic signed [SUM_W-1:0]     s1_sum_reg;
    logic signed [VALUE_BITS-1:0] s1_center_reg;
    hds_pkg::arith_ctl_t         s2_ctl_reg;
    logic signed [PROD_W-1:0]    s2_prod_reg;
    logic signed [VALUE_BITS-1:0] s2_center_reg;
    hds_pkg::arith_ctl_t         s3_ctl_reg;
    logic signed [V_W-1:0]       s3_value_reg;

    logic signed [SUM_W-1:0]     sum;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    rounded;
    logic signed [Q_W-1:0]       q;
    logic signed [V_W-1:0]       value;

    assign sum = SUM_W'(left) + SUM_W'(right) + SUM_W'(up) + SUM_W'(down)
               - (SUM_W'(center) <<< 2);

    assign prod = PROD_W'(s1_sum_reg) * PROD_W'($signed({1'b0, alpha}));

    assign rounded = s2_prod_reg + ROUND_HALF;
    assign q       = rounded[PROD_W-1:hds_pkg::ALPHA_BITS];
    assign value   = s2_ctl_reg.sten ? (V_W'(s2_center_reg) + V_W'(q))
                                     : V_W'(s2_center_reg);

    // Control bits advance every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sum_reg    <= sum;
        s1_center_reg <= center;
        s2_prod_reg   <= prod;
        s2_center_reg <= s1_center_reg;
        s3_value_reg  <= value;
    end

    // Clamp to the signed value range on the way out
    always_comb
    begin
        if (s3_value_reg > SAT_HI)
        begin
            out_value = SAT_HI[VALUE_BITS-1:0];
        end
        else if (s3_value_reg < SAT_LO)
        begin
            out_value = SAT_LO[VALUE_BITS-1:0];
        end
        else
        begin
            out_value = s3_value_reg[VALUE_BITS-1:0];
        end
    end

    assign out_ctl   = s3_ctl_reg;
    assign in_flight = hds_pkg::STAGE_COUNT_BITS'(s1_ctl_reg.valid)
                     + hds_pkg::STAGE_COUNT_BITS'(s2_ctl_reg.valid)
                     + hds_pkg::STAGE_COUNT_BITS'(s3_ctl_reg.valid);

endmodule
